### design/hbp_pkg.sv
// Package for the Huffman bit packer: widths, request codes and helper types.
// Depends on nothing; every other file of the block uses it.
package hbp_pkg;

	localparam int SYMBOLS         = 256;
	localparam int SYM_W           = 8;
	localparam int CODE_W          = 16;
	localparam int LEN_W           = 5;
	localparam int CODE_LENGTH_MAX = 16;
	localparam int BYTE_W          = 8;
	localparam int PEND_W          = BYTE_W - 1;
	localparam int CNT_W           = 3;
	localparam int ACC_W           = CODE_W + PEND_W;
	localparam int TOTAL_W         = 5;
	localparam int ALIGN_W         = 4 * BYTE_W;
	localparam int SHIFT_W         = 6;
	localparam int FUNC_W          = 2;
	localparam int ENTRY_W         = CODE_W + LEN_W;

	localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ENCODE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 2'd2;

	typedef logic [SYM_W-1:0]   sym_t;
	typedef logic [CODE_W-1:0]  code_t;
	typedef logic [LEN_W-1:0]   len_t;
	typedef logic [BYTE_W-1:0]  byte_t;
	typedef logic [FUNC_W-1:0]  func_t;

	typedef struct packed {
		len_t  len;
		code_t code;
	} entry_t;

endpackage

### design/hbp_if.sv
// Handshake interfaces for the request and result channels of the bit packer.
// Depends on hbp_pkg for the payload types.
interface hbp_req_if;
	logic               valid;
	logic               ready;
	hbp_pkg::func_t     func;
	hbp_pkg::sym_t      symbol;
	hbp_pkg::code_t     code_bits;
	hbp_pkg::len_t      code_length;

	modport source (output valid, output func, output symbol, output code_bits,
		output code_length, input ready);
	modport sink (input valid, input func, input symbol, input code_bits,
		input code_length, output ready);
endinterface

interface hbp_res_if;
	logic               valid;
	logic               ready;
	hbp_pkg::byte_t     packed_byte;
	logic               last;

	modport source (output valid, output packed_byte, output last, input ready);
	modport sink (input valid, input packed_byte, input last, output ready);
endinterface

### design/huffman_bit_packer_top.sv
// Top level of the Huffman bit packer: code table memory, bit accumulator and result buffer.
// Depends on hbp_pkg and the interfaces in hbp_if.sv.
//
// The req channel takes one request per cycle while req.ready is high: a load
// writes one code table entry, an encode looks up a byte's code and packs its
// bits, a flush pads the pending bits with zeros and gives one byte. The res
// channel gives packed bytes, earliest bit in the most significant position,
// with last set on the final byte caused by a request.
// An accepted request is held in a stage while the synchronous table read
// completes; its bytes then enter a two-entry result buffer once it has room,
// and the first byte is offered on res from there.
// An encode that gives two bytes occupies the result buffer until both have
// left, so the rate is set by the single result port at one byte per cycle
// while res.ready is high; the stage can pass on a request as the last byte leaves.
// Reset clears the pending bits, the stage and the buffer; the table contents are
// undefined until loaded. When the receiver stalls, the buffer holds its bytes,
// the stage waits, and req.ready falls once the stage is occupied.
module huffman_bit_packer_top (
	input  logic     clk,
	input  logic     arst_n,
	hbp_req_if.sink  req,
	hbp_res_if.source res
);
	import hbp_pkg::*;

	entry_t                 table_mem [SYMBOLS];
	entry_t                 rd_s1;
	logic                   valid_s1;
	func_t                  func_s1;
	logic                   inrange_s1;
	logic [PEND_W-1:0]      pend_q;
	logic [CNT_W-1:0]       pcnt_q;
	byte_t                  buf0_q;
	byte_t                  buf1_q;
	logic [1:0]             bcnt_q;

	logic                   req_fire;
	logic                   res_fire;
	logic                   go;
	logic                   sym_ok;
	len_t                   ld_len;
	logic [CODE_W:0]        ld_mask;
	entry_t                 ld_entry;
	len_t                   enc_len;
	logic [ACC_W-1:0]       comb;
	logic [TOTAL_W-1:0]     total;
	logic [ALIGN_W-1:0]     aligned;
	logic [PEND_W-1:0]      rem_mask;
	byte_t                  flush_word;

	assign sym_ok   = ({1'b0, req.symbol} < (SYM_W + 1)'(SYMBOLS));
	assign res_fire = res.valid && res.ready;
	assign go       = (bcnt_q == 2'd0) || ((bcnt_q == 2'd1) && res.ready);
	assign req.ready = !valid_s1 || go;
	assign req_fire = req.valid && req.ready;

	always_comb begin
		ld_len = req.code_length;
		if (ld_len > LEN_W'(CODE_W)) begin
			ld_len = LEN_W'(CODE_W);
		end
		if (ld_len > LEN_W'(CODE_LENGTH_MAX)) begin
			ld_len = LEN_W'(CODE_LENGTH_MAX);
		end
		ld_mask = ((CODE_W + 1)'(1) << ld_len) - (CODE_W + 1)'(1);
		ld_entry.len  = ld_len;
		ld_entry.code = req.code_bits & ld_mask[CODE_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (req_fire && (req.func == FUNC_LOAD) && sym_ok) begin
			table_mem[req.symbol] <= ld_entry;
		end
		if (req_fire) begin
			rd_s1 <= table_mem[req.symbol];
		end
	end

	always_comb begin
		enc_len    = inrange_s1 ? rd_s1.len : '0;
		comb       = (ACC_W'(pend_q) << enc_len) | ACC_W'(rd_s1.code);
		total      = TOTAL_W'(pcnt_q) + enc_len;
		aligned    = ALIGN_W'(comb) << (SHIFT_W'(ALIGN_W) - SHIFT_W'(total));
		rem_mask   = (PEND_W'(1) << total[CNT_W-1:0]) - PEND_W'(1);
		flush_word = {pend_q, 1'b0} << CNT_W'(PEND_W - int'(pcnt_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			func_s1    <= FUNC_LOAD;
			inrange_s1 <= 1'b0;
			pend_q     <= '0;
			pcnt_q     <= '0;
			bcnt_q     <= '0;
		end else begin
			if (req_fire) begin
				valid_s1   <= (req.func == FUNC_ENCODE) || (req.func == FUNC_FLUSH);
				func_s1    <= req.func;
				inrange_s1 <= sym_ok;
			end else if (go) begin
				valid_s1 <= 1'b0;
			end
			if (valid_s1 && go) begin
				if (func_s1 == FUNC_FLUSH) begin
					bcnt_q <= 2'd1;
					pend_q <= '0;
					pcnt_q <= '0;
				end else begin
					bcnt_q <= total[TOTAL_W-1:CNT_W];
					pend_q <= comb[PEND_W-1:0] & rem_mask;
					pcnt_q <= total[CNT_W-1:0];
				end
			end else if (res_fire) begin
				bcnt_q <= bcnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && go) begin
			if (func_s1 == FUNC_FLUSH) begin
				buf0_q <= flush_word;
			end else begin
				buf0_q <= aligned[ALIGN_W-1 -: BYTE_W];
				buf1_q <= aligned[ALIGN_W-BYTE_W-1 -: BYTE_W];
			end
		end else if (res_fire) begin
			buf0_q <= buf1_q;
		end
	end

	assign res.valid       = (bcnt_q != 2'd0);
	assign res.packed_byte = buf0_q;
	assign res.last        = (bcnt_q == 2'd1);

endmodule
